### rtl/core/dor_pkg.sv
// shared types, constants and helpers for the degree order edge relabel block
package dor_pkg;

    localparam int VID_W        = 16;
    localparam int DEG_W        = 16;
    localparam int CNT_W        = 17;
    localparam int ADDR_W       = 16;
    localparam int NUM_VERTICES = 1 << ADDR_W;
    localparam int MAX_DEGREE   = 65535;

    localparam logic [1:0] CMD_DEGREE = 2'd0;
    localparam logic [1:0] CMD_ORIENT = 2'd1;
    localparam logic [1:0] CMD_BUILD  = 2'd2;
    localparam logic [1:0] CMD_EMIT   = 2'd3;

    typedef struct packed
    {
        logic [1:0]       cmd;
        logic [VID_W-1:0] src;
        logic [VID_W-1:0] dst;
    } item_t;

    typedef struct packed
    {
        logic [VID_W-1:0] oriented_src;
        logic [VID_W-1:0] oriented_dst;
        logic [VID_W-1:0] src_label;
        logic [VID_W-1:0] dst_label;
        logic [DEG_W-1:0] max_out_degree;
        logic [CNT_W-1:0] vertex_count;
        logic             saturated;
    } result_t;

    // msb is the saturation mark, low bits the new count
    function automatic logic [DEG_W:0] bump(input logic [DEG_W-1:0] c);
        logic [DEG_W:0] r;
        if (c >= DEG_W'(MAX_DEGREE))
        begin
            r = {1'b1, DEG_W'(MAX_DEGREE)};
        end
        else
        begin
            r = {1'b0, c + DEG_W'(1)};
        end
        return r;
    endfunction

    // true when the endpoints must be swapped so the lower degree, or on a tie the larger id, is the source
    function automatic logic orient_swap(input logic [DEG_W-1:0] ds,
                                         input logic [DEG_W-1:0] dd,
                                         input logic [VID_W-1:0] s,
                                         input logic [VID_W-1:0] d);
        return (ds > dd) || ((ds == dd) && (s < d));
    endfunction

endpackage

### rtl/core/dor_ram_1r.sv
// single read port synchronous memory
module dor_ram_1r #(
    parameter int DW = dor_pkg::DEG_W,
    parameter int AW = dor_pkg::ADDR_W
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:(1<<AW)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/dor_ram_2r.sv
// two read port synchronous memory
module dor_ram_2r #(
    parameter int DW = dor_pkg::DEG_W,
    parameter int AW = dor_pkg::ADDR_W
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [DW-1:0] rdata_a,
    output logic [DW-1:0] rdata_b
);

    logic [DW-1:0] mem [0:(1<<AW)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### rtl/core/degree_order_edge_relabel.sv
// top level: command sequencer around the degree, out-degree, bucket and label memories
//
//  channel   signals              handshake
//  -------   -------------------  ---------------------------------
//  item      start, busy, item    taken at clk edge with start & !busy
//  result    done, result         one cycle, strobe done, no stall
//
// after reset a clearing pass zeroes degree, out-degree and bucket stores; busy is high
// cmd 0 bumps the source, then the destination degree (one write port per memory);
// cmd 1 orients, then bumps the source out-degree; cmd 3 reads labels, then orients
// cmd 2 clears the buckets, counts out-degrees, prefix-sums them, then writes the labels
// result appears the cycle after the last step; done cannot be held off
module degree_order_edge_relabel (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  dor_pkg::item_t  item,
    output logic            done,
    output dor_pkg::result_t result
);

    localparam int AW = dor_pkg::ADDR_W;
    localparam int DW = dor_pkg::DEG_W;
    localparam int CW = dor_pkg::CNT_W;
    localparam logic [CW-1:0] LAST_V = CW'(dor_pkg::NUM_VERTICES - 1);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_C0A  = 4'd2;
    localparam logic [3:0] S_C0B  = 4'd3;
    localparam logic [3:0] S_C1A  = 4'd4;
    localparam logic [3:0] S_C1B  = 4'd5;
    localparam logic [3:0] S_C3A  = 4'd6;
    localparam logic [3:0] S_BCLR = 4'd7;
    localparam logic [3:0] S_BCNT = 4'd8;
    localparam logic [3:0] S_BPFX = 4'd9;
    localparam logic [3:0] S_BLAB = 4'd10;

    logic [3:0]    state_reg, state_next;
    logic [1:0]    phase_reg, phase_next;
    logic [CW-1:0] v_reg, v_next;
    logic [CW-1:0] run_reg, run_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] maxd_reg, maxd_next;
    logic [AW-1:0] highest_reg, highest_next;
    logic          sat_reg, sat_next;
    logic [AW-1:0] dv_reg, dv_next;
    logic [AW-1:0] s_reg, s_next;
    logic [AW-1:0] d_reg, d_next;
    logic [AW-1:0] osrc_reg, osrc_next;
    logic [DW-1:0] tmp_reg, tmp_next;
    logic          done_reg, done_next;
    dor_pkg::result_t res_reg, res_next;

    logic          deg_we, odeg_we, bkt_we, lab_we;
    logic [AW-1:0] deg_wa, odeg_wa, bkt_wa;
    logic [DW-1:0] deg_wd, odeg_wd, lab_wd;
    logic [CW-1:0] bkt_wd;
    logic [AW-1:0] deg_ra, deg_rb, odeg_ra, bkt_ra, lab_ra, lab_rb;
    logic [DW-1:0] deg_qa, deg_qb, odeg_q, lab_qa, lab_qb;
    logic [CW-1:0] bkt_q;

    logic          swap;
    logic [DW:0]   bmp;

    dor_ram_2r #(.DW(DW), .AW(AW)) u_deg (
        .clk(clk), .we(deg_we), .waddr(deg_wa), .wdata(deg_wd),
        .raddr_a(deg_ra), .raddr_b(deg_rb), .rdata_a(deg_qa), .rdata_b(deg_qb)
    );

    dor_ram_1r #(.DW(DW), .AW(AW)) u_odeg (
        .clk(clk), .we(odeg_we), .waddr(odeg_wa), .wdata(odeg_wd),
        .raddr(odeg_ra), .rdata(odeg_q)
    );

    dor_ram_1r #(.DW(CW), .AW(AW)) u_bkt (
        .clk(clk), .we(bkt_we), .waddr(bkt_wa), .wdata(bkt_wd),
        .raddr(bkt_ra), .rdata(bkt_q)
    );

    dor_ram_2r #(.DW(DW), .AW(AW)) u_lab (
        .clk(clk), .we(lab_we), .waddr(v_reg[AW-1:0]), .wdata(lab_wd),
        .raddr_a(lab_ra), .raddr_b(lab_rb), .rdata_a(lab_qa), .rdata_b(lab_qb)
    );

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    assign swap = dor_pkg::orient_swap(deg_qa, deg_qb, s_reg, d_reg);

    // read addresses
    always_comb
    begin
        deg_ra  = (state_reg == S_IDLE) ? item.src : s_reg;
        deg_rb  = (state_reg == S_IDLE) ? item.dst : d_reg;
        lab_ra  = (state_reg == S_IDLE) ? item.src : s_reg;
        lab_rb  = (state_reg == S_IDLE) ? item.dst : d_reg;
        odeg_ra = (state_reg == S_C1A) ? (swap ? d_reg : s_reg) : v_reg[AW-1:0];
        bkt_ra  = (state_reg == S_BPFX) ? v_reg[AW-1:0] : odeg_q;
    end

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        v_next       = v_reg;
        run_next     = run_reg;
        cnt_next     = cnt_reg;
        maxd_next    = maxd_reg;
        highest_next = highest_reg;
        sat_next     = sat_reg;
        dv_next      = dv_reg;
        s_next       = s_reg;
        d_next       = d_reg;
        osrc_next    = osrc_reg;
        tmp_next     = tmp_reg;
        res_next     = res_reg;
        done_next    = 1'b0;
        deg_we  = 1'b0;  deg_wa  = s_reg;           deg_wd  = '0;
        odeg_we = 1'b0;  odeg_wa = osrc_reg;        odeg_wd = '0;
        bkt_we  = 1'b0;  bkt_wa  = dv_reg;          bkt_wd  = '0;
        lab_we  = 1'b0;  lab_wd  = '0;
        bmp     = '0;

        unique case (state_reg)
            S_CLR:
            begin
                deg_we = 1'b1;  deg_wa  = v_reg[AW-1:0];
                odeg_we = 1'b1; odeg_wa = v_reg[AW-1:0];
                bkt_we = 1'b1;  bkt_wa  = v_reg[AW-1:0];
                v_next = v_reg + CW'(1);
                if (v_reg == LAST_V)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    s_next = item.src;
                    d_next = item.dst;
                    unique case (item.cmd)
                        dor_pkg::CMD_DEGREE:
                        begin
                            state_next = S_C0A;
                            if ((item.src > highest_reg) && (item.src >= item.dst))
                            begin
                                highest_next = item.src;
                            end
                            else if (item.dst > highest_reg)
                            begin
                                highest_next = item.dst;
                            end
                        end
                        dor_pkg::CMD_ORIENT:
                        begin
                            state_next = S_C1A;
                        end
                        dor_pkg::CMD_BUILD:
                        begin
                            state_next = S_BCLR;
                            cnt_next   = {1'b0, highest_reg} + CW'(1);
                            maxd_next  = '0;
                            v_next     = '0;
                        end
                        dor_pkg::CMD_EMIT:
                        begin
                            state_next = S_C3A;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_C0A:
            begin
                bmp = dor_pkg::bump(deg_qa);
                deg_we = 1'b1; deg_wa = s_reg; deg_wd = bmp[DW-1:0];
                tmp_next = bmp[DW-1:0];
                sat_next = sat_reg | bmp[DW];
                state_next = S_C0B;
            end
            S_C0B:
            begin
                // self-loop: the second bump builds on the first
                bmp = dor_pkg::bump((s_reg == d_reg) ? tmp_reg : deg_qb);
                deg_we = 1'b1; deg_wa = d_reg; deg_wd = bmp[DW-1:0];
                sat_next = sat_reg | bmp[DW];
                state_next = S_IDLE;
            end
            S_C1A:
            begin
                osrc_next  = swap ? d_reg : s_reg;
                state_next = S_C1B;
            end
            S_C1B:
            begin
                bmp = dor_pkg::bump(odeg_q);
                odeg_we = 1'b1; odeg_wa = osrc_reg; odeg_wd = bmp[DW-1:0];
                sat_next = sat_reg | bmp[DW];
                state_next = S_IDLE;
            end
            S_C3A:
            begin
                res_next = '0;
                res_next.oriented_src = swap ? d_reg : s_reg;
                res_next.oriented_dst = swap ? s_reg : d_reg;
                res_next.src_label    = swap ? lab_qb : lab_qa;
                res_next.dst_label    = swap ? lab_qa : lab_qb;
                res_next.saturated    = sat_reg;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_BCLR:
            begin
                bkt_we = 1'b1; bkt_wa = v_reg[AW-1:0];
                v_next = v_reg + CW'(1);
                if (v_reg == LAST_V)
                begin
                    v_next     = '0;
                    phase_next = 2'd0;
                    state_next = S_BCNT;
                end
            end
            S_BCNT:
            begin
                unique case (phase_reg)
                    2'd0:
                    begin
                        phase_next = 2'd1;
                    end
                    2'd1:
                    begin
                        dv_next = odeg_q;
                        if (odeg_q > maxd_reg)
                        begin
                            maxd_next = odeg_q;
                        end
                        phase_next = 2'd2;
                    end
                    default:
                    begin
                        bkt_we = 1'b1; bkt_wa = dv_reg; bkt_wd = bkt_q + CW'(1);
                        phase_next = 2'd0;
                        v_next = v_reg + CW'(1);
                        if (v_reg + CW'(1) == cnt_reg)
                        begin
                            v_next     = '0;
                            run_next   = '0;
                            state_next = S_BPFX;
                        end
                    end
                endcase
            end
            S_BPFX:
            begin
                if (phase_reg == 2'd0)
                begin
                    phase_next = 2'd1;
                end
                else
                begin
                    // count becomes the first position of its bucket
                    bkt_we = 1'b1; bkt_wa = v_reg[AW-1:0]; bkt_wd = run_reg;
                    run_next = run_reg + bkt_q;
                    phase_next = 2'd0;
                    v_next = v_reg + CW'(1);
                    if (v_reg == LAST_V)
                    begin
                        v_next     = '0;
                        state_next = S_BLAB;
                    end
                end
            end
            S_BLAB:
            begin
                unique case (phase_reg)
                    2'd0:
                    begin
                        phase_next = 2'd1;
                    end
                    2'd1:
                    begin
                        dv_next    = odeg_q;
                        phase_next = 2'd2;
                    end
                    default:
                    begin
                        bkt_we = 1'b1; bkt_wa = dv_reg; bkt_wd = bkt_q + CW'(1);
                        lab_we = 1'b1;
                        lab_wd = DW'(cnt_reg - CW'(1) - bkt_q);
                        phase_next = 2'd0;
                        v_next = v_reg + CW'(1);
                        if (v_reg + CW'(1) == cnt_reg)
                        begin
                            res_next = '0;
                            res_next.max_out_degree = maxd_reg;
                            res_next.vertex_count   = cnt_reg;
                            res_next.saturated      = sat_reg;
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            phase_reg   <= '0;
            v_reg       <= '0;
            highest_reg <= '0;
            sat_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            v_reg       <= v_next;
            highest_reg <= highest_next;
            sat_reg     <= sat_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg  <= run_next;
        cnt_reg  <= cnt_next;
        maxd_reg <= maxd_next;
        dv_reg   <= dv_next;
        s_reg    <= s_next;
        d_reg    <= d_next;
        osrc_reg <= osrc_next;
        tmp_reg  <= tmp_next;
        res_reg  <= res_next;
    end

`ifndef NO_ASSERTIONS
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_C3A || state_reg == S_BLAB))
        else $error("result without finishing work");

    a_sat_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        sat_reg |=> sat_reg)
        else $error("saturation flag dropped");

    a_c0b_follows: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_C0B |-> $past(state_reg == S_C0A))
        else $error("second degree bump out of order");

    a_build_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && res_reg.vertex_count != '0) |->
            (res_reg.oriented_src == '0 && res_reg.src_label == '0))
        else $error("build result carries edge fields");
`endif

endmodule

### test/dor_checker.sv
// checker for the degree order edge relabel block: predicts each result and compares it
module dor_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  dor_pkg::item_t   item,
    input  logic             done,
    input  dor_pkg::result_t result,
    output int               errors,
    output int               waiting,
    output int               checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW   = dor_pkg::VID_W;
    localparam int DW   = dor_pkg::DEG_W;
    localparam int CW   = dor_pkg::CNT_W;
    localparam int MAXD = dor_pkg::MAX_DEGREE;
    localparam int NV   = dor_pkg::NUM_VERTICES;

    logic [DW-1:0]    deg_tab    [NV];
    logic [DW-1:0]    outdeg_tab [NV];
    logic [VW-1:0]    label_tab  [NV];
    int               bucket     [MAXD+1];
    logic [VW-1:0]    hi_vid;
    logic             sat_flag;
    dor_pkg::result_t expected_results[$];
    int               err_cnt;
    int               chk_cnt;

    assign errors  = err_cnt;
    assign checked = chk_cnt;

    initial
    begin
        foreach (deg_tab[i])
        begin
            deg_tab[i]    = '0;
            outdeg_tab[i] = '0;
            label_tab[i]  = '0;
        end
        hi_vid   = '0;
        sat_flag = 1'b0;
        err_cnt  = 0;
        chk_cnt  = 0;
    end

    function automatic logic [DW-1:0] count_up(input logic [DW-1:0] c);
        if (c == DW'(MAXD))
        begin
            sat_flag = 1'b1;
            return c;
        end
        return c + 1'b1;
    endfunction

    // counting sort of 0..hi_vid by out-degree, stable by id
    function automatic void relabel(output logic [DW-1:0] maxd,
                                    output logic [CW-1:0] n);
        int cnt;
        int run;
        int c;
        int pos;
        cnt  = int'(hi_vid) + 1;
        maxd = '0;
        foreach (bucket[k])
            bucket[k] = 0;
        for (int v = 0; v < cnt; v++)
        begin
            if (outdeg_tab[v] > maxd)
                maxd = outdeg_tab[v];
            bucket[outdeg_tab[v]]++;
        end
        run = 0;
        for (int k = 0; k <= MAXD; k++)
        begin
            c         = bucket[k];
            bucket[k] = run;
            run      += c;
        end
        for (int v = 0; v < cnt; v++)
        begin
            pos = bucket[outdeg_tab[v]];
            bucket[outdeg_tab[v]] = pos + 1;
            label_tab[v] = VW'(cnt - 1 - pos);
        end
        n = CW'(cnt);
    endfunction

    function automatic bit predict(input dor_pkg::item_t it, output dor_pkg::result_t r);
        logic [VW-1:0] s;
        logic [VW-1:0] d;
        logic [VW-1:0] t;
        s = it.src;
        d = it.dst;
        r = '0;
        if (it.cmd == dor_pkg::CMD_DEGREE)
        begin
            deg_tab[s] = count_up(deg_tab[s]);
            deg_tab[d] = count_up(deg_tab[d]);
            if (s > hi_vid)
                hi_vid = s;
            if (d > hi_vid)
                hi_vid = d;
            return 1'b0;
        end
        // lower degree endpoint becomes the source, larger id on a tie
        if (it.cmd != dor_pkg::CMD_BUILD &&
            (deg_tab[s] > deg_tab[d] || (deg_tab[s] == deg_tab[d] && s < d)))
        begin
            t = s;
            s = d;
            d = t;
        end
        if (it.cmd == dor_pkg::CMD_ORIENT)
        begin
            outdeg_tab[s] = count_up(outdeg_tab[s]);
            return 1'b0;
        end
        if (it.cmd == dor_pkg::CMD_BUILD)
        begin
            relabel(r.max_out_degree, r.vertex_count);
        end
        else
        begin
            r.oriented_src = s;
            r.oriented_dst = d;
            r.src_label    = label_tab[s];
            r.dst_label    = label_tab[d];
        end
        r.saturated = sat_flag;
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin
        dor_pkg::result_t r;
        dor_pkg::result_t e;
        if (rst_n)
        begin
            if (start && !busy && predict(item, r))
                expected_results.insert(expected_results.size(), r);
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("[%0t] result with no item waiting: %p", $realtime, result);
                end
                else
                begin
                    e = expected_results.pop_front();
                    chk_cnt++;
                    if (result.oriented_src   !== e.oriented_src   ||
                        result.oriented_dst   !== e.oriented_dst   ||
                        result.src_label      !== e.src_label      ||
                        result.dst_label      !== e.dst_label      ||
                        result.max_out_degree !== e.max_out_degree ||
                        result.vertex_count   !== e.vertex_count   ||
                        result.saturated      !== e.saturated)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                        begin
                            $display("[%0t] result differs", $realtime);
                            $display("    expected %p", e);
                            $display("    actual   %p", result);
                        end
                    end
                end
            end
            waiting <= expected_results.size();
        end
    end

endmodule

### test/tb.sv
// testbench top: edge stimulus over all passes, idle patterns, timeout and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int VW          = dor_pkg::VID_W;

    logic             clk   = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    dor_pkg::item_t   item  = '0;
    logic             busy;
    logic             done;
    dor_pkg::result_t result;
    int               errors;
    int               waiting;
    int               checked;

    int      idle_pct;
    int      top_id      = 0;   // highest id seen by a degree pass
    int      labelled_hi = -1;  // ids up to here carry a label
    int      items_sent  = 0;
    int      builds      = 0;
    longint  cycles      = 0;

    degree_order_edge_relabel dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    dor_checker chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result),
        .errors  (errors),
        .waiting (waiting),
        .checked (checked)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic push(input logic [1:0] cmd, input int s, input int d);
        dor_pkg::item_t it;
        it.cmd = cmd;
        it.src = VW'(s);
        it.dst = VW'(d);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        // busy read at the edge still holds its pre-edge value
        do
            @(posedge clk);
        while (busy);
        items_sent++;
        if (cmd == dor_pkg::CMD_DEGREE)
        begin
            if (s > top_id)
                top_id = s;
            if (d > top_id)
                top_id = d;
        end
        if (cmd == dor_pkg::CMD_BUILD)
        begin
            labelled_hi = top_id;
            builds++;
        end
    endtask

    task automatic emit_labelled();
        push(dor_pkg::CMD_EMIT, $urandom_range(labelled_hi), $urandom_range(labelled_hi));
    endtask

    // random mix of degree, orient and emit items; emits only touch labelled ids
    task automatic mixed_items(input int n, input int idmax);
        int r;
        int s;
        int d;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            s = $urandom_range(idmax);
            d = ($urandom_range(9) == 0) ? s : $urandom_range(idmax);
            if (r < 40)
                push(dor_pkg::CMD_DEGREE, s, d);
            else if (r < 70 || labelled_hi < 0)
                push(dor_pkg::CMD_ORIENT, s, d);
            else
                emit_labelled();
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // sender idles now and then
        idle_pct = 8;
        push(dor_pkg::CMD_DEGREE, 0, 0);
        push(dor_pkg::CMD_DEGREE, 5, 3);
        push(dor_pkg::CMD_DEGREE, 3, 5);
        push(dor_pkg::CMD_DEGREE, 7, 2);
        push(dor_pkg::CMD_ORIENT, 0, 0);
        push(dor_pkg::CMD_ORIENT, 5, 3);
        push(dor_pkg::CMD_ORIENT, 3, 5);
        push(dor_pkg::CMD_ORIENT, 2, 7);
        push(dor_pkg::CMD_ORIENT, 9, 1);      // beyond the highest id of the degree pass
        push(dor_pkg::CMD_BUILD, 0, 0);
        push(dor_pkg::CMD_EMIT, 0, 0);
        push(dor_pkg::CMD_EMIT, 5, 3);
        push(dor_pkg::CMD_EMIT, 2, 7);
        push(dor_pkg::CMD_EMIT, 7, 2);
        mixed_items(150, 40);
        push(dor_pkg::CMD_BUILD, 0, 0);
        mixed_items(250, 40);

        // sender mostly idle; repeated passes pile onto old counts
        idle_pct = 81;
        mixed_items(300, 100);
        push(dor_pkg::CMD_BUILD, $urandom, $urandom);
        mixed_items(150, 100);

        // back to back, full id range
        idle_pct = 0;
        push(dor_pkg::CMD_DEGREE, 65535, 0);
        push(dor_pkg::CMD_DEGREE, 65535, 65535);
        push(dor_pkg::CMD_ORIENT, 65535, 0);
        push(dor_pkg::CMD_ORIENT, 0, 65535);
        mixed_items(200, 65535);
        push(dor_pkg::CMD_BUILD, 65535, 65535);
        push(dor_pkg::CMD_EMIT, 65535, 0);
        push(dor_pkg::CMD_EMIT, 0, 65535);
        push(dor_pkg::CMD_EMIT, 65535, 65535);
        mixed_items(400, 65535);

        // a last orient on low ids, then emits over the labelled range
        push(dor_pkg::CMD_ORIENT, 0, 1);
        for (int i = 0; i < 20; i++)
            emit_labelled();
        push(dor_pkg::CMD_EMIT, 0, 65535);

        start <= 1'b0;
        while (waiting != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("%0d items over %0d label builds, %0d results checked",
                 items_sent, builds, checked);
        $display("sender idle at 8%%, 81%% and 0%% across the three phases");
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
